FILE: rtl/bdq_pkg.sv
// Package with the shared types, sizes and ring helpers of the bounded deque.
`timescale 1ns / 1ps
package bdq_pkg;

  // Store size and the widths that follow from it.
  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = PTR_W + 1;

  // Fixed field widths of the words on the two channels.
  localparam int KIND_W = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int COUNT_W = 7;
  localparam int STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_READ       = 3'd4,
    KIND_CLEAR      = 3'd5
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_FETCH = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_out;
  } cmd_t;

  // Ring position that lies off entries after ptr; off is at most DEPTH.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {2'b00, ptr} + {1'b0, off};
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // Ring position just before ptr.
  function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == '0) begin
      res = PTR_W'(DEPTH - 1);
    end else begin
      res = ptr - 1'b1;
    end
    return res;
  endfunction

endpackage

FILE: rtl/bdq_ctrl.sv
// Controller state machine of the bounded deque: sequences accept, fetch and output load.
`timescale 1ns / 1ps
module bdq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output bdq_pkg::cmd_t cmd
);
  import bdq_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state: an accepted word waits in fetch until the output register is free.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: handshake and datapath commands.
  always_comb begin
    in_stall     = 1'b1;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_FETCH: begin
        cmd.load_out = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // The output register fills on a load and empties when its word is taken.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  a_accept_fetch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_FETCH))
    else $error("accepted word did not move the controller to fetch");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("output load did not raise out_valid");

  a_wait_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_FETCH && out_valid && out_stall) |=> (state == S_FETCH))
    else $error("fetch left while the output register was still occupied");

endmodule

FILE: rtl/bdq_datapath.sv
// Datapath of the bounded deque: element memory, ring pointer, count and output register.
`timescale 1ns / 1ps
module bdq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  bdq_pkg::cmd_t                       cmd,
  input  logic        [bdq_pkg::KIND_W-1:0]   kind,
  input  logic signed [bdq_pkg::DATA_W-1:0]   value,
  input  logic        [bdq_pkg::POS_W-1:0]    position,
  output logic signed [bdq_pkg::DATA_W-1:0]   read_value,
  output logic        [bdq_pkg::COUNT_W-1:0]  count,
  output logic                                is_empty,
  output logic        [bdq_pkg::STAT_W-1:0]   status
);
  import bdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_q;

  logic [PTR_W-1:0] front_ptr;
  logic [CNT_W-1:0] elem_count;
  status_t          op_status;
  logic             op_read;

  logic [PTR_W-1:0] front_ptr_next;
  logic [CNT_W-1:0] elem_count_next;
  status_t          op_status_next;
  logic             op_read_next;
  logic             wr_en;
  logic             rd_en;
  logic [PTR_W-1:0] wr_addr;
  logic [PTR_W-1:0] rd_addr;
  logic             full;
  logic             empty;

  assign full  = (elem_count >= CNT_W'(DEPTH));
  assign empty = (elem_count == '0);

  // Decode of one operation against the current pointer and count.
  always_comb begin
    front_ptr_next  = front_ptr;
    elem_count_next = elem_count;
    op_status_next  = ST_OK;
    op_read_next    = 1'b0;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    wr_addr         = ring_dec(front_ptr);
    rd_addr         = ring_add(front_ptr, CNT_W'(position));
    case (kind_t'(kind))
      KIND_PUSH_FRONT: begin
        if (full) begin
          op_status_next = ST_FULL;
        end else begin
          front_ptr_next  = ring_dec(front_ptr);
          wr_en           = 1'b1;
          elem_count_next = elem_count + 1'b1;
        end
      end
      KIND_PUSH_BACK: begin
        wr_addr = ring_add(front_ptr, elem_count);
        if (full) begin
          op_status_next = ST_FULL;
        end else begin
          wr_en           = 1'b1;
          elem_count_next = elem_count + 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          op_status_next = ST_EMPTY;
        end else begin
          front_ptr_next  = ring_add(front_ptr, CNT_W'(1));
          elem_count_next = elem_count - 1'b1;
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          op_status_next = ST_EMPTY;
        end else begin
          elem_count_next = elem_count - 1'b1;
        end
      end
      KIND_READ: begin
        if (CNT_W'(position) >= elem_count) begin
          op_status_next = ST_RANGE;
        end else begin
          rd_en        = 1'b1;
          op_read_next = 1'b1;
        end
      end
      KIND_CLEAR: begin
        front_ptr_next  = '0;
        elem_count_next = '0;
      end
      default: begin
        op_status_next = ST_OK;
      end
    endcase
  end

  // Pointer and count update on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_ptr  <= '0;
      elem_count <= '0;
    end else if (cmd.accept) begin
      front_ptr  <= front_ptr_next;
      elem_count <= elem_count_next;
    end
  end

  // Per-word decode results held until the output load.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_status <= op_status_next;
      op_read   <= op_read_next;
    end
  end

  // Element memory with one write or one registered read per word.
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_en) begin
      mem[wr_addr] <= value;
    end
    if (cmd.accept && rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Output register, loaded once the controller sees it free.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_value <= op_read ? mem_q : '0;
      count      <= COUNT_W'(elem_count);
      is_empty   <= empty;
      status     <= op_status;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    elem_count <= CNT_W'(DEPTH))
    else $error("element count exceeds the store depth");

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (is_empty == (count == '0)))
    else $error("empty flag disagrees with the count in the output word");

endmodule

FILE: rtl/bounded_deque_with_index_read.sv
// Bounded deque with index read: top level joining controller and datapath.
//
// Each input word carries one operation (push front, push back, pop front,
// pop back, read at a position from the front, or clear) in kind, with the
// push data in value and the read index in position. Every word produces
// exactly one output word: read_value (the element read, zero otherwise),
// count after the operation, is_empty and a status code.
// Both channels use valid and stall; a word moves on a rising edge where
// valid is high and stall is low.
// The result of an accepted word is held in the datapath (registered memory
// read and status) and loaded into the output register once that is free.
// The next word is not accepted until the previous one has been loaded into
// the output register, since the controller stalls the input while in fetch.
// If the receiver stalls, the result waits in the output register; the next
// word is still accepted, and its result waits in the datapath until the
// output register is taken. in_stall stays high while a word is in flight.
// Reset empties the deque (count and front pointer zero); no clearing pass
// is needed since only entries inside the count are ever read.
`timescale 1ns / 1ps
module bounded_deque_with_index_read (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [bdq_pkg::KIND_W-1:0]   kind,
  input  logic signed [bdq_pkg::DATA_W-1:0]   value,
  input  logic        [bdq_pkg::POS_W-1:0]    position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bdq_pkg::DATA_W-1:0]   read_value,
  output logic        [bdq_pkg::COUNT_W-1:0]  count,
  output logic                                is_empty,
  output logic        [bdq_pkg::STAT_W-1:0]   status
);
  import bdq_pkg::*;

  cmd_t cmd;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bdq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .kind       (kind),
    .value      (value),
    .position   (position),
    .read_value (read_value),
    .count      (count),
    .is_empty   (is_empty),
    .status     (status)
  );

endmodule
